/* src/clkmon_pkg.sv */
// ----------------------------------------------------------------------------
// Clock frequency monitor package
// Shared widths, constants and types for the monitor core and its units.
// ----------------------------------------------------------------------------
package clkmon_pkg;

  // Field widths
  localparam int unsigned CNT_W   = 32;   // capture count, delta, error
  localparam int unsigned NOM_W   = 26;   // nominal frequency register
  localparam int unsigned SNUM_W  = 16;   // sample number
  localparam int unsigned AVG_W   = 39;   // window average in hundredths
  localparam int unsigned SUM_W   = 36;   // window running sum
  localparam int unsigned NUM_WIN = 4;    // windows of 2, 4, 8, 16 deltas
  localparam int unsigned OUT_W   = SNUM_W + 2 * CNT_W + NUM_WIN * AVG_W + NUM_WIN;

  // History depth exponent default
  localparam int unsigned HIST_EXP_DEF = 4;

  // Nominal register reset value
  localparam logic [NOM_W-1:0] NOM_RESET = NOM_W'(32768);

  // Error scaling: below the limit err*10000/(nom/100), else err*1000/(nom/1000)
  localparam int unsigned KMUL_W       = 14;
  localparam int unsigned LO_NOM_LIMIT = 100000;
  localparam logic [KMUL_W-1:0] K_LO   = KMUL_W'(10000);
  localparam logic [KMUL_W-1:0] K_HI   = KMUL_W'(1000);
  localparam int unsigned PROD_W       = CNT_W + KMUL_W;

  // Shared divider sizing
  localparam int unsigned REM_W     = 17;  // covers nom/1000 for a 26-bit nom
  localparam int unsigned ITER_W    = 6;
  localparam logic [REM_W-1:0] DIV_LO = REM_W'(100);
  localparam logic [REM_W-1:0] DIV_HI = REM_W'(1000);
  localparam logic [ITER_W-1:0] QUO_ITER = ITER_W'(CNT_W);

  // Divisor by reciprocal multiplication
  // nom/100 for nom below the limit: (nom * ceil(2^24/100)) >> 24
  // nom/1000 for any 26-bit nom:     (nom * ceil(2^36/1000)) >> 36
  localparam int unsigned NOM_LO_W  = 17;
  localparam int unsigned RCP_LO_W  = 18;
  localparam int unsigned RCP_LO_SH = 24;
  localparam int unsigned RLO_P_W   = NOM_LO_W + RCP_LO_W;
  localparam logic [RCP_LO_W-1:0] RCP_LO = RCP_LO_W'(167773);
  localparam int unsigned RCP_HI_W  = 27;
  localparam int unsigned RCP_HI_SH = 36;
  localparam int unsigned RHI_P_W   = NOM_W + RCP_HI_W;
  localparam logic [RCP_HI_W-1:0] RCP_HI = RCP_HI_W'(68719477);

  // Average scaling
  localparam int unsigned AVG_SCALE = 100;
  localparam int unsigned SCALE_W   = SUM_W + 7;

  // Divider request and response
  typedef struct packed {
    logic              start;
    logic [ITER_W-1:0] iter;
    logic [REM_W-1:0]  rem_init;
    logic [CNT_W-1:0]  dividend;
    logic [REM_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [CNT_W-1:0] quotient;
  } div_rsp_t;

  // Window unit status
  typedef struct packed {
    logic               busy;
    logic [NUM_WIN-1:0] valid;
  } win_stat_t;

  typedef logic [NUM_WIN-1:0][AVG_W-1:0] avg_vec_t;

endpackage

/* src/clkmon_div.sv */
// ----------------------------------------------------------------------------
// Clock monitor shared divider
// Restoring divider, one quotient bit per cycle, with a preloaded remainder.
// ----------------------------------------------------------------------------
module clkmon_div import clkmon_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [ITER_W-1:0] cnt_q, cnt_d;
  logic [REM_W-1:0]  rem_q, rem_d;
  logic [CNT_W-1:0]  lo_q, lo_d;
  logic [REM_W-1:0]  div_q, div_d;

  logic [REM_W:0] trial;
  logic [REM_W:0] diff;
  logic           ge;

  // One shift-subtract step
  always_comb begin
    trial = {rem_q, lo_q[CNT_W-1]};
    diff  = trial - {1'b0, div_q};
    ge    = (trial >= {1'b0, div_q});
  end

  // Step sequencing
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    lo_d   = lo_q;
    div_d  = div_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = req_i.iter;
      rem_d  = req_i.rem_init;
      lo_d   = req_i.dividend;
      div_d  = req_i.divisor;
    end else if (busy_q) begin
      rem_d = ge ? diff[REM_W-1:0] : trial[REM_W-1:0];
      lo_d  = {lo_q[CNT_W-2:0], ge};
      cnt_d = cnt_q - ITER_W'(1);
      if (cnt_q == ITER_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    lo_q  <= lo_d;
    div_q <= div_d;
  end

  assign rsp_o.busy     = busy_q;
  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = lo_q;

endmodule

/* src/clkmon_win.sv */
// ----------------------------------------------------------------------------
// Clock monitor window unit
// Delta history memory and running window sums, updated one window at a time.
// ----------------------------------------------------------------------------
module clkmon_win import clkmon_pkg::*; #(
  parameter int unsigned HIST_EXP = HIST_EXP_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [CNT_W-1:0] delta_i,
  output win_stat_t        stat_o,
  output avg_vec_t         avg_o
);

  localparam int unsigned HIST_SIZE = 1 << HIST_EXP;
  localparam int unsigned IDX_W     = $clog2(HIST_EXP);
  localparam int unsigned FILL_W    = HIST_EXP + 1;
  localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(HIST_SIZE + 1);

  // Sequencer codes
  localparam logic [2:0] W_IDLE = 3'd0;
  localparam logic [2:0] W_RD   = 3'd1;
  localparam logic [2:0] W_ACC  = 3'd2;
  localparam logic [2:0] W_AVG  = 3'd3;
  localparam logic [2:0] W_WR   = 3'd4;

  logic [2:0]          state_q, state_d;
  logic [IDX_W-1:0]    idx_q, idx_d;
  logic [FILL_W-1:0]   fill_q, fill_d;
  logic [HIST_EXP-1:0] wptr_q, wptr_d;
  logic [SUM_W-1:0]    sums_q [HIST_EXP];
  logic [AVG_W-1:0]    avg_q  [HIST_EXP];
  logic [CNT_W-1:0]    delta_q;
  logic [CNT_W-1:0]    rd_q;
  logic [CNT_W-1:0]    hist_mem [HIST_SIZE];

  logic [IDX_W:0]      shamt;
  logic [FILL_W-1:0]   sps;
  logic [HIST_EXP-1:0] rd_addr;
  logic [SUM_W-1:0]    old_val;
  logic [SUM_W-1:0]    sum_next;
  logic [SCALE_W-1:0]  scaled;
  logic [SCALE_W-1:0]  shifted;

  // Window size and oldest slot for the current window
  always_comb begin
    shamt   = {1'b0, idx_q} + (IDX_W+1)'(1);
    sps     = FILL_W'(1) << shamt;
    rd_addr = wptr_q - sps[HIST_EXP-1:0];
    old_val = (fill_q > sps) ? SUM_W'(rd_q) : '0;
    sum_next = sums_q[idx_q] + SUM_W'(delta_q) - old_val;
    scaled  = SCALE_W'(sums_q[idx_q]) * SCALE_W'(AVG_SCALE);
    shifted = scaled >> shamt;
  end

  // Sequencer
  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    fill_d  = fill_q;
    wptr_d  = wptr_q;
    unique case (state_q)
      W_IDLE: begin
        if (start_i) begin
          state_d = W_RD;
          idx_d   = '0;
          if (fill_q < FILL_MAX) begin
            fill_d = fill_q + FILL_W'(1);
          end
        end
      end
      W_RD:  state_d = W_ACC;
      W_ACC: state_d = W_AVG;
      W_AVG: begin
        if (idx_q == IDX_W'(HIST_EXP - 1)) begin
          state_d = W_WR;
        end else begin
          idx_d   = idx_q + IDX_W'(1);
          state_d = W_RD;
        end
      end
      W_WR: begin
        wptr_d  = wptr_q + HIST_EXP'(1);
        state_d = W_IDLE;
      end
      default: state_d = W_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= W_IDLE;
      idx_q   <= '0;
      fill_q  <= '0;
      wptr_q  <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      fill_q  <= fill_d;
      wptr_q  <= wptr_d;
    end
  end

  // Running sums start at zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < HIST_EXP; k++) begin
        sums_q[k] <= '0;
      end
    end else if (state_q == W_ACC) begin
      sums_q[idx_q] <= sum_next;
    end
  end

  // Delta latch and averages
  always_ff @(posedge clk_i) begin
    if (state_q == W_IDLE && start_i) begin
      delta_q <= delta_i;
    end
    if (state_q == W_AVG) begin
      avg_q[idx_q] <= (fill_q >= sps) ? shifted[AVG_W-1:0] : '0;
    end
  end

  // History memory: one read port, one write port
  always_ff @(posedge clk_i) begin
    rd_q <= hist_mem[rd_addr];
    if (state_q == W_WR) begin
      hist_mem[wptr_q] <= delta_q;
    end
  end

  // Per-window outputs; absent windows read zero
  for (genvar k = 0; k < NUM_WIN; k++) begin : g_win
    if (k < HIST_EXP) begin : g_on
      assign stat_o.valid[k] = (fill_q >= FILL_W'(2 << k));
      assign avg_o[k]        = avg_q[k];
    end else begin : g_off
      assign stat_o.valid[k] = 1'b0;
      assign avg_o[k]        = '0;
    end
  end

  assign stat_o.busy = (state_q != W_IDLE);

endmodule

/* src/clock_frequency_monitor_core.sv */
// ----------------------------------------------------------------------------
// Clock frequency monitor core
// Sequencing: a priming item gives no result; every later item passes the
//   error, multiply and quotient states, the 32 quotient steps of the shared
//   divider (skipped when the error saturates) and the output state, which
//   waits for the window unit and output register; new items wait for idle.
// Reset: asynchronous, active low; clears the sequencer, primed flag, counters,
//   window sums and fill, and sets the nominal frequency to 32768.
// ----------------------------------------------------------------------------
module clock_frequency_monitor_core import clkmon_pkg::*; #(
  parameter int unsigned HIST_EXP = HIST_EXP_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  // Input items
  input  logic             s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  logic [CNT_W-1:0] s_axis_tdata_i,   // [31:0] capture_count
  // Result items
  output logic             m_axis_tvalid_o,
  input  logic             m_axis_tready_i,
  output logic [OUT_W-1:0] m_axis_tdata_o,   // [15:0] sample_number,
                                             // [47:16] delta_ticks,
                                             // [79:48] error_ppm,
                                             // [118:80] avg_two_x100,
                                             // [157:119] avg_four_x100,
                                             // [196:158] avg_eight_x100,
                                             // [235:197] avg_sixteen_x100,
                                             // [239:236] window_valid
  // Configuration
  input  logic             cfg_we_i,
  input  logic [NOM_W-1:0] cfg_wdata_i        // nominal clock frequency in Hz
);

  // Sequencer codes
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_ERR  = 3'd1;
  localparam logic [2:0] ST_MUL  = 3'd2;
  localparam logic [2:0] ST_QUO  = 3'd3;
  localparam logic [2:0] ST_MAIN = 3'd4;
  localparam logic [2:0] ST_OUT  = 3'd5;

  logic [2:0]        state_q, state_d;
  logic              primed_q;
  logic [CNT_W-1:0]  prev_q;
  logic [SNUM_W-1:0] interval_q;
  logic [NOM_W-1:0]  nom_q;
  logic              out_valid_q;
  logic [OUT_W-1:0]  out_data_q;

  logic [CNT_W-1:0]  delta_q;
  logic [CNT_W-1:0]  err_q;
  logic [PROD_W-1:0] prod_q;
  logic [REM_W-1:0]  den_q;
  logic [CNT_W-1:0]  ppm_q;

  logic               in_acc;
  logic               item_go;
  logic [CNT_W-1:0]   delta_in;
  logic               lo_mode;
  logic [KMUL_W-1:0]  kmul;
  logic [RLO_P_W-1:0] den_lo_prod;
  logic [RHI_P_W-1:0] den_hi_prod;
  logic [REM_W-1:0]   den_d;
  logic [CNT_W-1:0]   nom_ext;
  logic [CNT_W-1:0]   err_d;
  logic               sat;
  logic               quo_go;
  logic               out_free;
  logic               out_load;

  div_req_t  div_req;
  div_rsp_t  div_rsp;
  win_stat_t win_stat;
  avg_vec_t  avg_vec;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign item_go         = in_acc && primed_q;
  assign delta_in        = s_axis_tdata_i - prev_q;

  // Error scaling selection, divisor and absolute error
  always_comb begin
    lo_mode     = (nom_q < NOM_W'(LO_NOM_LIMIT));
    kmul        = lo_mode ? K_LO : K_HI;
    den_lo_prod = RLO_P_W'(nom_q[NOM_LO_W-1:0]) * RLO_P_W'(RCP_LO);
    den_hi_prod = RHI_P_W'(nom_q) * RHI_P_W'(RCP_HI);
    den_d       = lo_mode ? REM_W'(den_lo_prod[RLO_P_W-1:RCP_LO_SH])
                          : den_hi_prod[RCP_HI_SH +: REM_W];
    nom_ext = CNT_W'(nom_q);
    err_d   = (delta_q >= nom_ext) ? (delta_q - nom_ext) : (nom_ext - delta_q);
    sat     = ({(REM_W - (PROD_W - CNT_W))'(0), prod_q[PROD_W-1:CNT_W]} >= den_q);
    quo_go  = (state_q == ST_QUO) && !sat;
  end

  // Divider request: quotient pass once the scaled error is ready
  always_comb begin
    div_req.start    = quo_go;
    div_req.iter     = QUO_ITER;
    div_req.rem_init = REM_W'(prod_q[PROD_W-1:CNT_W]);
    div_req.dividend = prod_q[CNT_W-1:0];
    div_req.divisor  = den_q;
  end

  clkmon_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  clkmon_win #(
    .HIST_EXP (HIST_EXP)
  ) u_win (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (item_go),
    .delta_i (delta_in),
    .stat_o  (win_stat),
    .avg_o   (avg_vec)
  );

  // Output register handoff
  assign out_free = !out_valid_q || m_axis_tready_i;
  assign out_load = (state_q == ST_OUT) && !win_stat.busy && out_free;

  // Item sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (item_go) state_d = ST_ERR;
      ST_ERR:  state_d = ST_MUL;
      ST_MUL:  state_d = ST_QUO;
      ST_QUO:  state_d = sat ? ST_OUT : ST_MAIN;
      ST_MAIN: if (div_rsp.done) state_d = ST_OUT;
      ST_OUT:  if (out_load) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      primed_q    <= 1'b0;
      prev_q      <= '0;
      interval_q  <= '0;
      nom_q       <= NOM_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        nom_q <= cfg_wdata_i;
      end
      if (in_acc) begin
        primed_q <= 1'b1;
        prev_q   <= s_axis_tdata_i;
      end
      if (item_go) begin
        interval_q <= interval_q + SNUM_W'(1);
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (item_go) begin
      delta_q <= delta_in;
    end
    err_q  <= err_d;
    prod_q <= PROD_W'(err_q) * PROD_W'(kmul);
    den_q  <= den_d;
    if (state_q == ST_QUO && sat) begin
      ppm_q <= '1;
    end else if (state_q == ST_MAIN && div_rsp.done) begin
      ppm_q <= div_rsp.quotient;
    end
    if (out_load) begin
      out_data_q <= {win_stat.valid, avg_vec[3], avg_vec[2], avg_vec[1], avg_vec[0],
                     ppm_q, delta_q, interval_q};
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  // Checks
  a_div_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

  a_win_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_go |-> !win_stat.busy)
    else $error("window unit started while busy");

  a_result_from_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == ST_OUT)
    else $error("result raised outside the output step");

  a_sat_all_ones: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_QUO && sat) |=> ppm_q == '1)
    else $error("saturated error not all ones");

endmodule

/* sim/freq_result_checker.sv */
// ----------------------------------------------------------------------------
// Clock frequency monitor result checker
// Watches the input, result and configuration ports of the monitor core and
// keeps its own model of the interval, error and moving-average logic. Every
// accepted result item is compared field by field with the oldest predicted
// one. Mismatches are counted and handed to the testbench top.
// ----------------------------------------------------------------------------
module freq_result_checker import clkmon_pkg::*; #(
  parameter int unsigned HIST_EXP = HIST_EXP_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_tvalid_i,
  input  logic             in_tready_i,
  input  logic [CNT_W-1:0] in_tdata_i,
  input  logic             res_tvalid_i,
  input  logic             res_tready_i,
  input  logic [OUT_W-1:0] res_tdata_i,
  input  logic             cfg_we_i,
  input  logic [NOM_W-1:0] cfg_wdata_i,
  output int unsigned      mismatch_count_o,
  output int unsigned      pending_results_o
);

  localparam int unsigned HIST_SIZE  = 1 << HIST_EXP;
  localparam int unsigned PRINT_MAX  = 200;

  // Result item, lowest field last
  typedef struct packed {
    logic [NUM_WIN-1:0] window_valid;
    avg_vec_t           avg_x100;       // [0] two deltas ... [3] sixteen deltas
    logic [CNT_W-1:0]   error_ppm;
    logic [CNT_W-1:0]   delta_ticks;
    logic [SNUM_W-1:0]  sample_number;
  } freq_result_t;

  // Model state
  logic [NOM_W-1:0]  nominal_q;
  bit                primed_q;
  logic [CNT_W-1:0]  last_count_q;
  logic [SNUM_W-1:0] interval_q;
  int unsigned       filled_q;
  logic [CNT_W-1:0]  deltas_q [HIST_SIZE];
  logic [SUM_W-1:0]  sums_q [NUM_WIN];
  freq_result_t      expected_q [$];

  // Absolute error in ppm, two scalings, saturated
  function automatic logic [CNT_W-1:0] ppm_error_of(input logic [CNT_W-1:0] delta,
                                                    input logic [NOM_W-1:0] nom);
    longint unsigned d, n, diff, scaled, divisor, quo;
    d = delta;
    n = nom;
    diff = (d >= n) ? d - n : n - d;
    if (n < LO_NOM_LIMIT) begin
      scaled  = diff * K_LO;
      divisor = n / DIV_LO;
    end else begin
      scaled  = diff * K_HI;
      divisor = n / DIV_HI;
    end
    if (divisor == 0) return '1;
    quo = scaled / divisor;
    if ((quo >> CNT_W) != 0) return '1;
    return CNT_W'(quo);
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    if (mismatch_count_o < PRINT_MAX)
      $display("MISMATCH %s: got 0x%0h expected 0x%0h at %0t", what, got, want, $realtime);
    mismatch_count_o++;
  endtask

  // One captured count: first one primes, later ones predict a result
  task automatic take_count(input logic [CNT_W-1:0] count);
    freq_result_t    want;
    logic [CNT_W-1:0] delta;
    int unsigned     slot, span;
    longint unsigned acc;
    if (!primed_q) begin
      primed_q     = 1'b1;
      last_count_q = count;
      return;
    end
    delta        = count - last_count_q;
    last_count_q = count;
    interval_q   = interval_q + 1'b1;
    if (filled_q < HIST_SIZE + 1) filled_q++;
    slot = (interval_q - 1) & (HIST_SIZE - 1);
    want = '0;
    for (int w = 0; w < HIST_EXP && w < NUM_WIN; w++) begin
      span = 2 << w;
      acc  = sums_q[w];
      acc  = acc + delta;
      // once full, the oldest delta drops out of the window
      if (filled_q > span) acc = acc - deltas_q[(slot + HIST_SIZE - span) % HIST_SIZE];
      sums_q[w] = SUM_W'(acc);
      acc = sums_q[w];
      if (filled_q >= span) begin
        want.window_valid[w] = 1'b1;
        want.avg_x100[w]     = AVG_W'(acc * AVG_SCALE / span);
      end
    end
    deltas_q[slot]     = delta;
    want.sample_number = interval_q;
    want.delta_ticks   = delta;
    want.error_ppm     = ppm_error_of(delta, nominal_q);
    expected_q.push_back(want);
  endtask

  task automatic check_result(input freq_result_t got);
    freq_result_t want;
    if (expected_q.size() == 0) begin
      report_mismatch("unexpected result", 64'(got.sample_number), '0);
      return;
    end
    want = expected_q.pop_front();
    if (got.sample_number !== want.sample_number)
      report_mismatch("sample_number", 64'(got.sample_number), 64'(want.sample_number));
    if (got.delta_ticks !== want.delta_ticks)
      report_mismatch("delta_ticks", 64'(got.delta_ticks), 64'(want.delta_ticks));
    if (got.error_ppm !== want.error_ppm)
      report_mismatch("error_ppm", 64'(got.error_ppm), 64'(want.error_ppm));
    for (int w = 0; w < NUM_WIN; w++) begin
      if (got.avg_x100[w] !== want.avg_x100[w])
        report_mismatch($sformatf("avg_x100[%0d]", w), 64'(got.avg_x100[w]),
                        64'(want.avg_x100[w]));
    end
    if (got.window_valid !== want.window_valid)
      report_mismatch("window_valid", 64'(got.window_valid), 64'(want.window_valid));
  endtask

  // Sample all channels at the rising edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nominal_q    = NOM_RESET;
      primed_q     = 1'b0;
      last_count_q = '0;
      interval_q   = '0;
      filled_q     = 0;
      for (int w = 0; w < NUM_WIN; w++) sums_q[w] = '0;
      expected_q.delete();
      mismatch_count_o = 0;
    end else begin
      if (res_tvalid_i && res_tready_i) check_result(freq_result_t'(res_tdata_i));
      if (in_tvalid_i && in_tready_i) take_count(in_tdata_i);
      if (cfg_we_i) nominal_q = cfg_wdata_i;
    end
    pending_results_o = expected_q.size();
  end

endmodule

/* sim/tb_clock_frequency_monitor_core.sv */
// ----------------------------------------------------------------------------
// Clock frequency monitor core testbench
// Feeds capture counts through the core under a series of nominal frequency
// settings, from the reset value through the register extremes. A directed
// opening covers counter wrap, zero and maximum deltas and full windows; the
// rest are random deltas, mostly near nominal. Both stream sides idle at
// random, with one phase free of idling. The checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_clock_frequency_monitor_core;
  import clkmon_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 600000;
  localparam int unsigned SETTLE_CYCLES = 80;    // above the result latency
  localparam int unsigned PHASES        = 10;
  localparam int unsigned RAND_PER_SET  = 72;
  localparam int unsigned STEADY_PHASE  = 3;
  localparam int unsigned IDLE_PCT      = 38;

  logic             clk_i      = 1'b0;
  logic             rst_ni     = 1'b0;
  logic             s_tvalid   = 1'b0;
  logic             s_tready;
  logic [CNT_W-1:0] s_tdata    = '0;
  logic             m_tvalid;
  logic             m_tready   = 1'b0;
  logic [OUT_W-1:0] m_tdata;
  logic             cfg_we     = 1'b0;
  logic [NOM_W-1:0] cfg_wdata  = '0;

  int unsigned      mismatch_count;
  int unsigned      pending_results;
  int unsigned      cycle_count = 0;
  bit               steady      = 1'b0;
  logic [CNT_W-1:0] last_sent   = '0;
  logic [NOM_W-1:0] nominal     = NOM_RESET;
  logic [NOM_W-1:0] nom_plan [PHASES];

  always #6 clk_i = ~clk_i;

  clock_frequency_monitor_core i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata)
  );

  freq_result_checker i_checker (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_tvalid_i       (s_tvalid),
    .in_tready_i       (s_tready),
    .in_tdata_i        (s_tdata),
    .res_tvalid_i      (m_tvalid),
    .res_tready_i      (m_tready),
    .res_tdata_i       (m_tdata),
    .cfg_we_i          (cfg_we),
    .cfg_wdata_i       (cfg_wdata),
    .mismatch_count_o  (mismatch_count),
    .pending_results_o (pending_results)
  );

  // Result backpressure
  always @(negedge clk_i) begin
    if (steady) m_tready <= 1'b1;
    else        m_tready <= ($urandom_range(0, 99) >= IDLE_PCT);
  end

  // Run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Offer one count, with random idle cycles ahead of it
  task automatic send_count(input logic [CNT_W-1:0] count);
    if (!steady) begin
      while ($urandom_range(0, 99) < IDLE_PCT) begin
        s_tvalid <= 1'b0;
        s_tdata  <= $urandom;
        @(negedge clk_i);
      end
    end
    s_tvalid  <= 1'b1;
    s_tdata   <= count;
    last_sent  = count;
    // ready only moves at the rising edge, so its value here holds through it
    while (!s_tready) @(negedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic send_delta(input logic [CNT_W-1:0] delta);
    send_count(last_sent + delta);
  endtask

  // Mostly near nominal, with wide, tiny and near-maximum deltas mixed in
  function automatic logic [CNT_W-1:0] random_delta();
    logic [CNT_W-1:0] spread;
    spread = CNT_W'(nominal / 50) + 5;
    case ($urandom_range(0, 9))
      5, 6:    return $urandom;
      7:       return $urandom_range(0, 255);
      8:       return '1 - $urandom_range(0, 255);
      default: return CNT_W'(nominal) + $urandom_range(0, 2 * spread) - spread;
    endcase
  endfunction

  // Drain all results, then let the core settle
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (pending_results != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_nominal(input logic [NOM_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    nominal    = value;
    @(negedge clk_i);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    nom_plan = '{NOM_W'(0), NOM_W'(99), NOM_W'(100), NOM_W'(99999), NOM_W'(100000),
                 NOM_W'(1000), NOM_W'(50000000), {NOM_W{1'b1}},
                 NOM_W'($urandom_range(1000, 50000000)),
                 NOM_W'($urandom_range(1000, 50000000))};
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset nominal: prime near the top so the next count wraps
    send_count(32'hFFFF_FFF0);
    send_delta(CNT_W'(NOM_RESET));
    send_delta('0);
    send_delta('1);
    send_delta(CNT_W'(NOM_RESET) - 1);
    send_delta(CNT_W'(NOM_RESET) + 1);
    // maximum deltas fill every window at the largest sums
    repeat (16) send_delta('1);
    repeat (RAND_PER_SET) send_delta(random_delta());

    // Tiny, boundary and extreme nominal settings
    for (int p = 0; p < PHASES; p++) begin
      wait_idle();
      write_nominal(nom_plan[p]);
      steady = (p == STEADY_PHASE);
      repeat (RAND_PER_SET) send_delta(random_delta());
      steady = 1'b0;
    end

    wait_idle();
    if (mismatch_count == 0) $display("DONE: 0 errors");
    else                     $display("DONE: errors detected");
    $finish;
  end

endmodule
